FILE: src/ctb_pkg.sv
// Package: shared constants, codes and widths of the CSV field tokenizer.
package ctb_pkg;

	// Sizing
	localparam int MAX_COLUMNS = 256;
	localparam int LENGTH_BITS = 16;
	localparam int FD_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	// Fixed field widths
	localparam int BYTE_W = 8;
	localparam int KIND_W = 3;
	localparam int COL_W = 8;
	localparam int FLEN_W = 16;
	localparam int CC_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0] SEPARATOR_RST = 8'd44;
	localparam logic [BYTE_W-1:0] WRAPPER_RST = 8'd34;
	localparam logic [CC_W-1:0] COLUMNS_RST = 9'd1;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_CONTENT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIELD_END = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ROW_END = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAD_AFTER_WRAP = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TOO_MANY = 3'd4;

	// Parser phases
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_UNWRAPPED = 2'd1;
	localparam logic [1:0] PH_WRAPPED = 2'd2;
	localparam logic [1:0] PH_AFTER_WRAP = 2'd3;

	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

endpackage

FILE: src/ctb_in_if.sv
// Interface: byte input channel.
interface ctb_in_if;
	logic valid;
	logic ready;
	logic [ctb_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

FILE: src/ctb_out_if.sv
// Interface: tagged byte result channel.
interface ctb_out_if;
	logic valid;
	logic ready;
	logic [ctb_pkg::BYTE_W-1:0] out_byte;
	logic [ctb_pkg::KIND_W-1:0] kind;
	logic [ctb_pkg::COL_W-1:0] column;
	logic [ctb_pkg::FLEN_W-1:0] field_length;

	modport source (output valid, output out_byte, output kind, output column,
		output field_length, input ready);
	modport sink (input valid, input out_byte, input kind, input column,
		input field_length, output ready);
endinterface

FILE: src/ctb_cfg_if.sv
// Interface: configuration register write channel.
interface ctb_cfg_if;
	logic valid;
	logic ready;
	logic [ctb_pkg::CFG_IDX_W-1:0] index;
	logic [ctb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/csv_row_field_tokenizer_core.sv
// Top level: CSV field tokenizer, one tagged result per input byte.
//
// Each accepted byte comes back as one item carrying the byte, its kind
// (content, field end, row end, bad byte after a closing wrapper, too many
// columns), its zero-based column and, on field and row ends, the saturating
// length of the field. One byte is taken every cycle: the parser state update
// is a single compare-and-select step, and the result sits in one output
// register, so an item's result is registered when its byte is accepted and the
// input stays ready as long as the output register is empty or being drained.
// Configuration writes are always accepted and take effect for the next byte.
module csv_row_field_tokenizer_core (
	input logic clk,
	input logic arst_n,
	ctb_in_if.sink bytes,
	ctb_out_if.source tokens,
	ctb_cfg_if.sink cfg
);

	// Configuration registers
	logic [ctb_pkg::BYTE_W-1:0] separator_q;
	logic [ctb_pkg::BYTE_W-1:0] wrapper_q;
	logic [ctb_pkg::CC_W-1:0] columns_q;

	// Parser state
	logic [1:0] phase_q;
	logic [ctb_pkg::FD_W-1:0] fields_done_q;
	logic [ctb_pkg::LENGTH_BITS-1:0] length_q;

	// Result register
	logic out_valid_q;
	logic [ctb_pkg::BYTE_W-1:0] out_byte_q;
	logic [ctb_pkg::KIND_W-1:0] kind_q;
	logic [ctb_pkg::COL_W-1:0] column_q;
	logic [ctb_pkg::FLEN_W-1:0] flen_q;

	logic accept;
	logic [31:0] eff_cols;
	logic [31:0] done_plus1;
	logic [31:0] col_wide;
	logic [63:0] len_wide;
	logic [ctb_pkg::LENGTH_BITS-1:0] len_inc;
	logic [ctb_pkg::BYTE_W-1:0] b;

	logic [1:0] phase_d;
	logic [ctb_pkg::FD_W-1:0] fields_done_d;
	logic [ctb_pkg::LENGTH_BITS-1:0] length_d;
	logic [ctb_pkg::KIND_W-1:0] kind_d;
	logic [ctb_pkg::FLEN_W-1:0] flen_d;
	logic field_end;
	logic row_end;
	logic bad_byte;
	logic count_byte;

	assign cfg.ready = 1'b1;
	assign bytes.ready = !out_valid_q || tokens.ready;
	assign accept = bytes.valid && bytes.ready;
	assign b = bytes.in_byte;

	// Column count clamped to 1..MAX_COLUMNS
	always_comb begin
		priority if (columns_q == '0) begin
			eff_cols = 32'd1;
		end else if (32'(columns_q) > 32'(ctb_pkg::MAX_COLUMNS)) begin
			eff_cols = 32'(ctb_pkg::MAX_COLUMNS);
		end else begin
			eff_cols = 32'(columns_q);
		end
	end

	assign done_plus1 = 32'(fields_done_q) + 32'd1;
	assign col_wide = 32'(fields_done_q);
	assign len_wide = 64'(length_q);
	// saturating content count
	assign len_inc = (length_q == ctb_pkg::LENGTH_MAX) ? length_q : length_q + 1'b1;

	// Phase decode: classify the byte
	always_comb begin
		phase_d = phase_q;
		field_end = 1'b0;
		row_end = 1'b0;
		bad_byte = 1'b0;
		count_byte = 1'b0;
		unique case (phase_q)
			ctb_pkg::PH_START: begin
				priority if (b == wrapper_q) begin
					count_byte = 1'b1;
					phase_d = ctb_pkg::PH_WRAPPED;
				end else if (b == separator_q) begin
					field_end = 1'b1;
				end else if (b == ctb_pkg::NEWLINE_BYTE) begin
					row_end = 1'b1;
				end else begin
					count_byte = 1'b1;
					phase_d = ctb_pkg::PH_UNWRAPPED;
				end
			end
			ctb_pkg::PH_UNWRAPPED: begin
				priority if (b == separator_q) begin
					field_end = 1'b1;
				end else if (b == ctb_pkg::NEWLINE_BYTE && done_plus1 >= eff_cols) begin
					row_end = 1'b1;
				end else begin
					count_byte = 1'b1;
				end
			end
			ctb_pkg::PH_WRAPPED: begin
				count_byte = 1'b1;
				if (b == wrapper_q) begin
					phase_d = ctb_pkg::PH_AFTER_WRAP;
				end
			end
			ctb_pkg::PH_AFTER_WRAP: begin
				priority if (b == wrapper_q) begin
					count_byte = 1'b1;
					phase_d = ctb_pkg::PH_WRAPPED;
				end else if (b == ctb_pkg::NEWLINE_BYTE) begin
					row_end = 1'b1;
				end else if (b == separator_q) begin
					field_end = 1'b1;
				end else begin
					bad_byte = 1'b1;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Field and row end handling
	always_comb begin
		kind_d = ctb_pkg::KIND_CONTENT;
		flen_d = '0;
		fields_done_d = fields_done_q;
		length_d = count_byte ? len_inc : length_q;
		priority if (bad_byte) begin
			// bad byte restarts the row
			kind_d = ctb_pkg::KIND_BAD_AFTER_WRAP;
			fields_done_d = '0;
			length_d = '0;
		end else if (row_end) begin
			kind_d = ctb_pkg::KIND_ROW_END;
			flen_d = len_wide[ctb_pkg::FLEN_W-1:0];
			fields_done_d = '0;
			length_d = '0;
		end else if (field_end) begin
			if (done_plus1 >= eff_cols) begin
				kind_d = ctb_pkg::KIND_TOO_MANY;
				fields_done_d = '0;
				length_d = '0;
			end else begin
				kind_d = ctb_pkg::KIND_FIELD_END;
				flen_d = len_wide[ctb_pkg::FLEN_W-1:0];
				fields_done_d = done_plus1[ctb_pkg::FD_W-1:0];
				length_d = '0;
			end
		end else begin
			kind_d = ctb_pkg::KIND_CONTENT;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= ctb_pkg::SEPARATOR_RST;
			wrapper_q <= ctb_pkg::WRAPPER_RST;
			columns_q <= ctb_pkg::COLUMNS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ctb_pkg::REG_SEPARATOR: separator_q <= cfg.data[ctb_pkg::BYTE_W-1:0];
				ctb_pkg::REG_WRAPPER: wrapper_q <= cfg.data[ctb_pkg::BYTE_W-1:0];
				ctb_pkg::REG_COLUMNS: columns_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ctb_pkg::PH_START;
			fields_done_q <= '0;
			length_q <= '0;
		end else if (accept) begin
			fields_done_q <= fields_done_d;
			length_q <= length_d;
			if (bad_byte || row_end || field_end) begin
				phase_q <= ctb_pkg::PH_START;
			end else begin
				phase_q <= phase_d;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= b;
			kind_q <= kind_d;
			column_q <= col_wide[ctb_pkg::COL_W-1:0];
			flen_q <= flen_d;
		end
	end

	assign tokens.valid = out_valid_q;
	assign tokens.out_byte = out_byte_q;
	assign tokens.kind = kind_q;
	assign tokens.column = column_q;
	assign tokens.field_length = flen_q;

endmodule
